>>> rtl/chlc_pkg.sv
// Package for the container header layout checker.
// Holds the field widths, the configuration register indexes and the
// structs passed between the pipeline stages. No dependencies.
package chlc_pkg;

    localparam int unsigned MAGIC_W   = 32;
    localparam int unsigned VER_W     = 16;
    localparam int unsigned OFF_W     = 64;
    localparam int unsigned COUNT_W   = 32;
    localparam int unsigned FSIZE_W   = 63;
    localparam int unsigned CFG16_W   = 16;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 32;

    localparam int unsigned ALIGN_BYTES = 4;
    localparam int unsigned ALIGN_BITS  = $clog2(ALIGN_BYTES);

    localparam int unsigned TBL_W     = COUNT_W + CFG16_W;
    localparam int unsigned NUM_SEC   = 4;
    localparam int unsigned NUM_PAIR  = NUM_SEC * (NUM_SEC - 1) / 2;
    localparam int unsigned NUM_ALIGN = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EXPECTED_MAGIC = 3'd0,
        CFG_EXPECTED_MAJOR = 3'd1,
        CFG_EXPECTED_MINOR = 3'd2,
        CFG_HEADER_BYTES   = 3'd3,
        CFG_RECORD_BYTES   = 3'd4
    } t_cfg_index;

    typedef struct packed {
        logic [MAGIC_W-1:0] expected_magic;
        logic [VER_W-1:0]   expected_major;
        logic [VER_W-1:0]   expected_minor;
        logic [CFG16_W-1:0] header_bytes;
        logic [CFG16_W-1:0] record_bytes;
    } t_cfg;

    typedef struct packed {
        logic [MAGIC_W-1:0] magic_word;
        logic [VER_W-1:0]   major_version;
        logic [VER_W-1:0]   minor_version;
        logic [OFF_W-1:0]   table_offset;
        logic [COUNT_W-1:0] asset_total;
        logic [OFF_W-1:0]   strings_offset;
        logic [OFF_W-1:0]   strings_size;
        logic [OFF_W-1:0]   payload_offset;
        logic [OFF_W-1:0]   payload_size;
        logic [FSIZE_W-1:0] file_bytes;
    } t_item;

    typedef struct packed {
        logic                 bad_magic;
        logic                 bad_version;
        logic [NUM_ALIGN-1:0] misaligned;
        logic [TBL_W-1:0]     table_size;
        logic [OFF_W-1:0]     table_offset;
        logic [OFF_W-1:0]     strings_offset;
        logic [OFF_W-1:0]     strings_size;
        logic [OFF_W-1:0]     payload_offset;
        logic [OFF_W-1:0]     payload_size;
        logic [FSIZE_W-1:0]   file_bytes;
    } t_prod;

    typedef struct packed {
        logic                           bad_magic;
        logic                           bad_version;
        logic [NUM_ALIGN-1:0]           misaligned;
        logic [NUM_SEC-1:0][OFF_W-1:0]  sec_off;
        logic [NUM_SEC-1:0][OFF_W-1:0]  sec_end;
        logic [NUM_SEC-1:0]             end_ovf;
        logic [FSIZE_W-1:0]             file_bytes;
    } t_span;

    typedef struct packed {
        logic                 bad_magic;
        logic                 bad_version;
        logic [NUM_ALIGN-1:0] misaligned;
        logic                 table_size_overflow;
        logic [NUM_SEC-1:0]   end_overflow;
        logic [NUM_SEC-1:0]   out_of_bounds;
        logic [NUM_PAIR-1:0]  overlaps;
        logic                 malformed;
        logic                 unsupported;
    } t_result;

endpackage

>>> rtl/chlc_if.sv
// Channel interfaces of the container header layout checker.
// Depends on chlc_pkg for the field widths.
interface chlc_cfg_if import chlc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] wr_index;
    logic [CFG_DAT_W-1:0] wr_data;

    modport source (output valid, output wr_index, output wr_data, input ready);
    modport sink   (input valid, input wr_index, input wr_data, output ready);
endinterface

interface chlc_item_if import chlc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [MAGIC_W-1:0] magic_word;
    logic [VER_W-1:0]   major_version;
    logic [VER_W-1:0]   minor_version;
    logic [OFF_W-1:0]   table_offset;
    logic [COUNT_W-1:0] asset_total;
    logic [OFF_W-1:0]   strings_offset;
    logic [OFF_W-1:0]   strings_size;
    logic [OFF_W-1:0]   payload_offset;
    logic [OFF_W-1:0]   payload_size;
    logic [FSIZE_W-1:0] file_bytes;

    modport source (output valid, output magic_word, output major_version,
                    output minor_version, output table_offset, output asset_total,
                    output strings_offset, output strings_size, output payload_offset,
                    output payload_size, output file_bytes, input ready);
    modport sink   (input valid, input magic_word, input major_version,
                    input minor_version, input table_offset, input asset_total,
                    input strings_offset, input strings_size, input payload_offset,
                    input payload_size, input file_bytes, output ready);
endinterface

interface chlc_result_if import chlc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 bad_magic;
    logic                 bad_version;
    logic [NUM_ALIGN-1:0] misaligned;
    logic                 table_size_overflow;
    logic [NUM_SEC-1:0]   end_overflow;
    logic [NUM_SEC-1:0]   out_of_bounds;
    logic [NUM_PAIR-1:0]  overlaps;
    logic                 malformed;
    logic                 unsupported;

    modport source (output valid, output bad_magic, output bad_version,
                    output misaligned, output table_size_overflow, output end_overflow,
                    output out_of_bounds, output overlaps, output malformed,
                    output unsupported, input ready);
    modport sink   (input valid, input bad_magic, input bad_version,
                    input misaligned, input table_size_overflow, input end_overflow,
                    input out_of_bounds, input overlaps, input malformed,
                    input unsupported, output ready);
endinterface

>>> rtl/chlc_cfg_regs.sv
// Configuration register file of the container header layout checker.
// Depends on chlc_pkg and the chlc_cfg_if interface.
module chlc_cfg_regs import chlc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    chlc_cfg_if.sink   i_cfg,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (t_cfg_index'(i_cfg.wr_index))
                CFG_EXPECTED_MAGIC: r_cfg.expected_magic <= i_cfg.wr_data[MAGIC_W-1:0];
                CFG_EXPECTED_MAJOR: r_cfg.expected_major <= i_cfg.wr_data[VER_W-1:0];
                CFG_EXPECTED_MINOR: r_cfg.expected_minor <= i_cfg.wr_data[VER_W-1:0];
                CFG_HEADER_BYTES:   r_cfg.header_bytes   <= i_cfg.wr_data[CFG16_W-1:0];
                CFG_RECORD_BYTES:   r_cfg.record_bytes   <= i_cfg.wr_data[CFG16_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

>>> rtl/chlc_mul_stage.sv
// First pipeline stage: identity checks, alignment checks and the asset
// table size product. Depends on chlc_pkg.
module chlc_mul_stage import chlc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    input  t_cfg  i_cfg,
    output logic  o_valid,
    input  logic  i_ready,
    output t_prod o_prod
);

    logic  r_valid;
    t_prod r_prod;
    t_prod n_prod;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_prod  = r_prod;

    always_comb begin
        n_prod.bad_magic     = i_item.magic_word != i_cfg.expected_magic;
        n_prod.bad_version   = (i_item.major_version != i_cfg.expected_major)
                            || (i_item.minor_version != i_cfg.expected_minor);
        n_prod.misaligned[0] = i_item.table_offset[ALIGN_BITS-1:0] != '0;
        n_prod.misaligned[1] = i_item.strings_offset[ALIGN_BITS-1:0] != '0;
        n_prod.misaligned[2] = i_item.strings_size[ALIGN_BITS-1:0] != '0;
        n_prod.misaligned[3] = i_item.payload_offset[ALIGN_BITS-1:0] != '0;
        n_prod.misaligned[4] = i_item.payload_size[ALIGN_BITS-1:0] != '0;
        n_prod.table_size    = TBL_W'(i_item.asset_total) * TBL_W'(i_cfg.record_bytes);
        n_prod.table_offset   = i_item.table_offset;
        n_prod.strings_offset = i_item.strings_offset;
        n_prod.strings_size   = i_item.strings_size;
        n_prod.payload_offset = i_item.payload_offset;
        n_prod.payload_size   = i_item.payload_size;
        n_prod.file_bytes     = i_item.file_bytes;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_prod <= n_prod;
        end
    end

endmodule

>>> rtl/chlc_end_stage.sv
// Second pipeline stage: start and end offset of each section, with the
// carry out of each end sum. Depends on chlc_pkg.
module chlc_end_stage import chlc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_prod i_prod,
    input  t_cfg  i_cfg,
    output logic  o_valid,
    input  logic  i_ready,
    output t_span o_span
);

    logic          r_valid;
    t_span         r_span;
    t_span         n_span;
    logic [OFF_W:0] w_end_table;
    logic [OFF_W:0] w_end_strings;
    logic [OFF_W:0] w_end_payload;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_span  = r_span;

    assign w_end_table   = {1'b0, i_prod.table_offset} + (OFF_W+1)'(i_prod.table_size);
    assign w_end_strings = {1'b0, i_prod.strings_offset} + {1'b0, i_prod.strings_size};
    assign w_end_payload = {1'b0, i_prod.payload_offset} + {1'b0, i_prod.payload_size};

    always_comb begin
        n_span.bad_magic   = i_prod.bad_magic;
        n_span.bad_version = i_prod.bad_version;
        n_span.misaligned  = i_prod.misaligned;
        n_span.file_bytes  = i_prod.file_bytes;
        n_span.sec_off[0]  = '0;
        n_span.sec_end[0]  = OFF_W'(i_cfg.header_bytes);
        n_span.end_ovf[0]  = 1'b0;
        n_span.sec_off[1]  = i_prod.table_offset;
        n_span.sec_end[1]  = w_end_table[OFF_W-1:0];
        n_span.end_ovf[1]  = w_end_table[OFF_W];
        n_span.sec_off[2]  = i_prod.strings_offset;
        n_span.sec_end[2]  = w_end_strings[OFF_W-1:0];
        n_span.end_ovf[2]  = w_end_strings[OFF_W];
        n_span.sec_off[3]  = i_prod.payload_offset;
        n_span.sec_end[3]  = w_end_payload[OFF_W-1:0];
        n_span.end_ovf[3]  = w_end_payload[OFF_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_span <= n_span;
        end
    end

endmodule

>>> rtl/chlc_judge_stage.sv
// Last pipeline stage: bounds and pairwise overlap compares, summaries, and
// the result register that feeds the output channel. Depends on chlc_pkg.
module chlc_judge_stage import chlc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_span   i_span,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;
    t_result n_result;

    function automatic logic f_overlap(input t_span s, input int unsigned a,
                                       input int unsigned b);
        return s.end_ovf[a] || s.end_ovf[b]
            || !((s.sec_end[a] <= s.sec_off[b]) || (s.sec_end[b] <= s.sec_off[a]));
    endfunction

    assign o_ready  = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_comb begin
        n_result.bad_magic           = i_span.bad_magic;
        n_result.bad_version         = i_span.bad_version;
        n_result.misaligned          = i_span.misaligned;
        n_result.table_size_overflow = 1'b0;
        n_result.end_overflow        = i_span.end_ovf;
        for (int i = 0; i < NUM_SEC; i++) begin
            n_result.out_of_bounds[i] = !i_span.end_ovf[i]
                && (i_span.sec_end[i] > OFF_W'(i_span.file_bytes));
        end
        n_result.overlaps[0] = f_overlap(i_span, 0, 1);
        n_result.overlaps[1] = f_overlap(i_span, 0, 2);
        n_result.overlaps[2] = f_overlap(i_span, 0, 3);
        n_result.overlaps[3] = f_overlap(i_span, 1, 2);
        n_result.overlaps[4] = f_overlap(i_span, 1, 3);
        n_result.overlaps[5] = f_overlap(i_span, 2, 3);
        n_result.malformed   = n_result.bad_magic || (|n_result.misaligned)
            || n_result.table_size_overflow || (|n_result.end_overflow)
            || (|n_result.out_of_bounds) || (|n_result.overlaps);
        n_result.unsupported = i_span.bad_version;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_result <= n_result;
        end
    end

endmodule

>>> rtl/container_header_layout_check_top.sv
// Top level of the container header layout checker.
// Depends on chlc_pkg, the chlc interfaces, chlc_cfg_regs and the three
// pipeline stages.
//
// Usage:
// The configuration channel writes five registers by index: expected magic,
// expected major and minor version, header section size and asset record
// size. It is always ready; writes to other indexes are dropped. Write it
// only while no header is in flight.
// Each transaction on the item channel carries one header plus the file size
// and produces exactly one transaction on the result channel with all fault
// masks and the malformed and unsupported summaries.
// From acceptance to a valid result, the header and the table size product are
// registered at the accepting edge, then the section ends in the end stage,
// then the result in the result register. One header is accepted every cycle
// while the result channel keeps up. When the receiver stalls, the pipeline
// fills and the item channel drops ready once all three stages hold a
// transaction.
// Reset clears all configuration registers to zero and empties the pipeline.
module container_header_layout_check_top import chlc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    chlc_cfg_if.sink    i_cfg,
    chlc_item_if.sink   i_item,
    chlc_result_if.source o_result
);

    t_cfg    w_cfg;
    t_item   w_item;
    t_prod   w_prod;
    t_span   w_span;
    t_result w_result;
    logic    w_prod_valid;
    logic    w_prod_ready;
    logic    w_span_valid;
    logic    w_span_ready;

    assign w_item.magic_word     = i_item.magic_word;
    assign w_item.major_version  = i_item.major_version;
    assign w_item.minor_version  = i_item.minor_version;
    assign w_item.table_offset   = i_item.table_offset;
    assign w_item.asset_total    = i_item.asset_total;
    assign w_item.strings_offset = i_item.strings_offset;
    assign w_item.strings_size   = i_item.strings_size;
    assign w_item.payload_offset = i_item.payload_offset;
    assign w_item.payload_size   = i_item.payload_size;
    assign w_item.file_bytes     = i_item.file_bytes;

    chlc_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    chlc_mul_stage u_mul_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_item.valid),
        .o_ready (i_item.ready),
        .i_item  (w_item),
        .i_cfg   (w_cfg),
        .o_valid (w_prod_valid),
        .i_ready (w_prod_ready),
        .o_prod  (w_prod)
    );

    chlc_end_stage u_end_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_prod_valid),
        .o_ready (w_prod_ready),
        .i_prod  (w_prod),
        .i_cfg   (w_cfg),
        .o_valid (w_span_valid),
        .i_ready (w_span_ready),
        .o_span  (w_span)
    );

    chlc_judge_stage u_judge_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_span_valid),
        .o_ready  (w_span_ready),
        .i_span   (w_span),
        .o_valid  (o_result.valid),
        .i_ready  (o_result.ready),
        .o_result (w_result)
    );

    assign o_result.bad_magic           = w_result.bad_magic;
    assign o_result.bad_version         = w_result.bad_version;
    assign o_result.misaligned          = w_result.misaligned;
    assign o_result.table_size_overflow = w_result.table_size_overflow;
    assign o_result.end_overflow        = w_result.end_overflow;
    assign o_result.out_of_bounds       = w_result.out_of_bounds;
    assign o_result.overlaps            = w_result.overlaps;
    assign o_result.malformed           = w_result.malformed;
    assign o_result.unsupported         = w_result.unsupported;

`ifndef SYNTHESIS
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.ready |-> i_item.ready)
        else $error("item channel stalled while the result channel is ready");

    a_oob_excl_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> ((o_result.out_of_bounds & o_result.end_overflow) == '0))
        else $error("section flagged both out of bounds and end overflow");

    a_ovf_overlaps_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.end_overflow[1]) |->
            (o_result.overlaps[0] && o_result.overlaps[3] && o_result.overlaps[4]))
        else $error("overflowing asset table end does not overlap every section");

    a_malformed_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && (o_result.overlaps != '0 || o_result.bad_magic))
            |-> o_result.malformed)
        else $error("fault flagged without the malformed summary");

    a_header_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (!o_result.end_overflow[0] && !o_result.table_size_overflow))
        else $error("overflow flagged where the operand widths rule it out");
`endif

endmodule

>>> tb/container_header_layout_check_top_tb.sv
// Testbench for container_header_layout_check_top: predicts the fault masks of every
// accepted header and checks each result transaction field by field, in order.
// Depends on chlc_pkg, the chlc channel interfaces and the top level of the checker.
`timescale 1ns / 100ps

module container_header_layout_check_top_tb;
    import chlc_pkg::*;

    localparam int unsigned PIPE_LATENCY   = 3;
    localparam int unsigned WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_DAT_W-1:0] data;
    } t_reg_write;

    logic i_clk = 1'b0;
    logic i_rst_n;

    chlc_cfg_if    cfg_bus ();
    chlc_item_if   header_bus ();
    chlc_result_if verdict_bus ();

    container_header_layout_check_top DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_bus),
        .i_item   (header_bus),
        .o_result (verdict_bus)
    );

    t_item       queued_headers [$];
    t_result     expected_verdicts [$];
    t_reg_write  register_writes [$];
    t_cfg        model_cfg;
    int unsigned mismatch_count;
    int unsigned quiet_cycles;
    int unsigned send_hold;
    int unsigned take_hold;
    bit          source_idles;
    bit          sink_idles;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_result judge_header(input t_item h, input t_cfg c);
        t_result      v;
        logic [127:0] table_product;
        logic [63:0]  start [NUM_SEC];
        logic [63:0]  span [NUM_SEC];
        logic [64:0]  stop [NUM_SEC];
        int unsigned  pair;
        v = '0;
        v.bad_magic   = h.magic_word != c.expected_magic;
        v.bad_version = (h.major_version != c.expected_major)
                     || (h.minor_version != c.expected_minor);
        v.misaligned  = {|h.payload_size[ALIGN_BITS-1:0], |h.payload_offset[ALIGN_BITS-1:0],
                         |h.strings_size[ALIGN_BITS-1:0], |h.strings_offset[ALIGN_BITS-1:0],
                         |h.table_offset[ALIGN_BITS-1:0]};
        table_product = 128'(h.asset_total) * 128'(c.record_bytes);
        v.table_size_overflow = |table_product[127:64];
        start[0] = '0;
        span[0]  = 64'(c.header_bytes);
        start[1] = h.table_offset;
        span[1]  = v.table_size_overflow ? '1 : table_product[63:0];
        start[2] = h.strings_offset;
        span[2]  = h.strings_size;
        start[3] = h.payload_offset;
        span[3]  = h.payload_size;
        for (int i = 0; i < NUM_SEC; i++) begin
            stop[i] = {1'b0, start[i]} + {1'b0, span[i]};
            v.end_overflow[i]  = stop[i][64];
            v.out_of_bounds[i] = !stop[i][64] && (stop[i][63:0] > 64'(h.file_bytes));
        end
        // An overflowing end overlaps everything; otherwise the spans are half-open.
        pair = 0;
        for (int i = 0; i < NUM_SEC; i++) begin
            for (int j = i + 1; j < NUM_SEC; j++) begin
                v.overlaps[pair] = stop[i][64] || stop[j][64]
                                || !(stop[i][63:0] <= start[j] || stop[j][63:0] <= start[i]);
                pair++;
            end
        end
        v.malformed = v.bad_magic || (|v.misaligned) || v.table_size_overflow
                   || (|v.end_overflow) || (|v.out_of_bounds) || (|v.overlaps);
        v.unsupported = v.bad_version;
        return v;
    endfunction

    function automatic t_item random_header(input t_cfg c);
        t_item                     h;
        logic [$bits(t_item)+31:0] noise;
        logic [63:0]               off [1:3];
        logic [63:0]               len [1:3];
        logic [63:0]               cursor;
        logic [63:0]               scale;
        logic [63:0]               wide;
        int unsigned               order [3];
        int unsigned               roll;
        int unsigned               s;
        int unsigned               t;
        int unsigned               j;
        int unsigned               tmp;
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
            for (int k = 0; k < $bits(t_item); k += 32) begin
                noise[k +: 32] = $urandom;
            end
            return noise[$bits(t_item)-1:0];
        end
        h.magic_word    = c.expected_magic;
        h.major_version = c.expected_major;
        h.minor_version = c.expected_minor;
        if ($urandom_range(0, 9) == 0) h.magic_word ^= 32'h1 << $urandom_range(0, 31);
        if ($urandom_range(0, 9) == 0) h.major_version = 16'($urandom);
        if ($urandom_range(0, 9) == 0) h.minor_version = c.expected_minor + 16'd1;
        h.asset_total = ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 24);
        scale  = ($urandom_range(0, 9) == 0) ? (64'd1 << $urandom_range(12, 40)) : 64'd1;
        len[1] = 64'(h.asset_total) * 64'(c.record_bytes);
        len[2] = (64'($urandom_range(0, 256)) * scale) & ~64'h3;
        len[3] = (64'($urandom_range(0, 4096)) * scale) & ~64'h3;
        order = '{1, 2, 3};
        for (int k = 2; k > 0; k--) begin
            j = $urandom_range(0, k);
            tmp = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
        cursor = (64'(c.header_bytes) + 64'd3) & ~64'h3;
        foreach (order[k]) begin
            cursor += 64'($urandom_range(0, 4)) * 64'd4;
            off[order[k]] = cursor;
            cursor = (cursor + len[order[k]] + 64'd3) & ~64'h3;
        end
        cursor += 64'($urandom_range(0, 1) * $urandom_range(0, 64));
        h.file_bytes = cursor[FSIZE_W-1:0];
        if (roll < 45) begin
            repeat ($urandom_range(1, 2)) begin
                s = $urandom_range(1, 3);
                case ($urandom_range(0, 7))
                    0: off[s] += 64'($urandom_range(1, 3));
                    1: len[$urandom_range(2, 3)] += 64'($urandom_range(1, 3));
                    2: off[s] = 64'd0 - 64'($urandom_range(0, 64)) * 64'd4;
                    3: begin
                        t = $urandom_range(2, 3);
                        len[t] = (64'd0 - off[t]) + 64'($urandom_range(0, 4)) * 64'd4 - 64'd8;
                    end
                    4: h.file_bytes = h.file_bytes - 63'($urandom_range(1, 16));
                    5: begin
                        t = $urandom_range(0, 3);
                        if (t == 0) off[s] = 64'($urandom_range(0, int'(c.header_bytes)));
                        else off[s] = off[t] + 64'($urandom_range(0, 64));
                    end
                    6: off[s] = {$urandom, $urandom};
                    default: begin
                        wide = {$urandom, $urandom};
                        h.file_bytes = wide[FSIZE_W-1:0];
                        h.asset_total = $urandom;
                    end
                endcase
            end
        end
        h.table_offset   = off[1];
        h.strings_offset = off[2];
        h.strings_size   = len[2];
        h.payload_offset = off[3];
        h.payload_size   = len[3];
        return h;
    endfunction

    function automatic t_cfg random_settings(input bit modest);
        t_cfg c;
        c.expected_magic = $urandom;
        c.expected_major = 16'($urandom);
        c.expected_minor = 16'($urandom);
        c.header_bytes   = modest ? 16'($urandom_range(0, 256)) : 16'($urandom);
        c.record_bytes   = modest ? 16'($urandom_range(1, 64)) : 16'($urandom);
        return c;
    endfunction

    task automatic check_field(input string label, input logic [5:0] want,
                               input logic [5:0] got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t: %s expected %0h actual %0h", $time, label, want, got);
        end
    endtask

    task automatic program_registers(input t_cfg c);
        logic [CFG_IDX_W-1:0] spare;
        spare = CFG_IDX_W'($urandom_range(int'(CFG_RECORD_BYTES) + 1, 2 ** CFG_IDX_W - 1));
        register_writes.push_back('{CFG_EXPECTED_MAGIC, c.expected_magic});
        register_writes.push_back('{CFG_EXPECTED_MAJOR, {16'($urandom), c.expected_major}});
        register_writes.push_back('{CFG_EXPECTED_MINOR, {16'($urandom), c.expected_minor}});
        register_writes.push_back('{CFG_HEADER_BYTES, {16'($urandom), c.header_bytes}});
        register_writes.push_back('{CFG_RECORD_BYTES, {16'($urandom), c.record_bytes}});
        register_writes.push_back('{spare, $urandom});
        @(negedge i_clk);
        while (register_writes.size() != 0 || cfg_bus.valid) @(negedge i_clk);
    endtask

    task automatic await_verdicts();
        @(negedge i_clk);
        while (queued_headers.size() != 0 || header_bus.valid || expected_verdicts.size() != 0)
            @(negedge i_clk);
        repeat (PIPE_LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic run_headers(input int unsigned amount, input bit idling);
        source_idles = idling && ($urandom_range(0, 3) != 0);
        sink_idles   = idling && ($urandom_range(0, 3) != 0);
        repeat (amount) queued_headers.push_back(random_header(model_cfg));
        await_verdicts();
    endtask

    always @(posedge i_clk) begin : cfg_driver
        t_reg_write w;
        if (!i_rst_n) begin
            cfg_bus.valid <= 1'b0;
        end else if (!cfg_bus.valid || cfg_bus.ready) begin
            if (register_writes.size() != 0) begin
                w = register_writes.pop_front();
                cfg_bus.valid    <= 1'b1;
                cfg_bus.wr_index <= w.index;
                cfg_bus.wr_data  <= w.data;
            end else begin
                cfg_bus.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : header_driver
        t_item h;
        if (!i_rst_n) begin
            header_bus.valid <= 1'b0;
            send_hold = 0;
        end else if (!header_bus.valid || header_bus.ready) begin
            if (send_hold != 0) begin
                send_hold--;
                header_bus.valid <= 1'b0;
            end else if (queued_headers.size() != 0 && source_idles
                         && $urandom_range(0, 5) == 0) begin
                send_hold = $urandom_range(0, 7);
                header_bus.valid <= 1'b0;
            end else if (queued_headers.size() != 0) begin
                h = queued_headers.pop_front();
                header_bus.valid          <= 1'b1;
                header_bus.magic_word     <= h.magic_word;
                header_bus.major_version  <= h.major_version;
                header_bus.minor_version  <= h.minor_version;
                header_bus.table_offset   <= h.table_offset;
                header_bus.asset_total    <= h.asset_total;
                header_bus.strings_offset <= h.strings_offset;
                header_bus.strings_size   <= h.strings_size;
                header_bus.payload_offset <= h.payload_offset;
                header_bus.payload_size   <= h.payload_size;
                header_bus.file_bytes     <= h.file_bytes;
            end else begin
                header_bus.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : verdict_ready_driver
        if (!i_rst_n) begin
            verdict_bus.ready <= 1'b0;
            take_hold = 0;
        end else if (take_hold != 0) begin
            take_hold--;
            verdict_bus.ready <= 1'b0;
        end else if (sink_idles && $urandom_range(0, 5) == 0) begin
            take_hold = $urandom_range(0, 7);
            verdict_bus.ready <= 1'b0;
        end else begin
            verdict_bus.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : verdict_monitor
        t_item   seen;
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            model_cfg = '0;
        end else begin
            if (header_bus.valid && header_bus.ready) begin
                seen = '{magic_word: header_bus.magic_word,
                         major_version: header_bus.major_version,
                         minor_version: header_bus.minor_version,
                         table_offset: header_bus.table_offset,
                         asset_total: header_bus.asset_total,
                         strings_offset: header_bus.strings_offset,
                         strings_size: header_bus.strings_size,
                         payload_offset: header_bus.payload_offset,
                         payload_size: header_bus.payload_size,
                         file_bytes: header_bus.file_bytes};
                expected_verdicts.push_back(judge_header(seen, model_cfg));
            end
            if (verdict_bus.valid && verdict_bus.ready) begin
                got = '{bad_magic: verdict_bus.bad_magic,
                        bad_version: verdict_bus.bad_version,
                        misaligned: verdict_bus.misaligned,
                        table_size_overflow: verdict_bus.table_size_overflow,
                        end_overflow: verdict_bus.end_overflow,
                        out_of_bounds: verdict_bus.out_of_bounds,
                        overlaps: verdict_bus.overlaps,
                        malformed: verdict_bus.malformed,
                        unsupported: verdict_bus.unsupported};
                if (expected_verdicts.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result expected none actual %h", $time, got);
                end else begin
                    want = expected_verdicts.pop_front();
                    check_field("bad_magic", 6'(want.bad_magic), 6'(got.bad_magic));
                    check_field("bad_version", 6'(want.bad_version), 6'(got.bad_version));
                    check_field("misaligned", 6'(want.misaligned), 6'(got.misaligned));
                    check_field("table_size_overflow", 6'(want.table_size_overflow),
                                6'(got.table_size_overflow));
                    check_field("end_overflow", 6'(want.end_overflow), 6'(got.end_overflow));
                    check_field("out_of_bounds", 6'(want.out_of_bounds),
                                6'(got.out_of_bounds));
                    check_field("overlaps", want.overlaps, got.overlaps);
                    check_field("malformed", 6'(want.malformed), 6'(got.malformed));
                    check_field("unsupported", 6'(want.unsupported), 6'(got.unsupported));
                end
            end
            if (cfg_bus.valid && cfg_bus.ready) begin
                case (t_cfg_index'(cfg_bus.wr_index))
                    CFG_EXPECTED_MAGIC: model_cfg.expected_magic = cfg_bus.wr_data;
                    CFG_EXPECTED_MAJOR: model_cfg.expected_major = cfg_bus.wr_data[VER_W-1:0];
                    CFG_EXPECTED_MINOR: model_cfg.expected_minor = cfg_bus.wr_data[VER_W-1:0];
                    CFG_HEADER_BYTES:   model_cfg.header_bytes = cfg_bus.wr_data[CFG16_W-1:0];
                    CFG_RECORD_BYTES:   model_cfg.record_bytes = cfg_bus.wr_data[CFG16_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (header_bus.valid && header_bus.ready)
            || (verdict_bus.valid && verdict_bus.ready) || (cfg_bus.valid && cfg_bus.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        t_cfg  directed;
        t_cfg  c;
        t_item base;
        t_item h;
        i_rst_n = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.wr_index = '0;
        cfg_bus.wr_data = '0;
        header_bus.valid = 1'b0;
        header_bus.magic_word = '0;
        header_bus.major_version = '0;
        header_bus.minor_version = '0;
        header_bus.table_offset = '0;
        header_bus.asset_total = '0;
        header_bus.strings_offset = '0;
        header_bus.strings_size = '0;
        header_bus.payload_offset = '0;
        header_bus.payload_size = '0;
        header_bus.file_bytes = '0;
        verdict_bus.ready = 1'b0;
        model_cfg = '0;
        mismatch_count = 0;
        quiet_cycles = 0;
        send_hold = 0;
        take_hold = 0;
        source_idles = 1'b0;
        sink_idles = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The registers still hold their reset values here.
        h = '0;
        queued_headers.push_back(h);
        h = '1;
        queued_headers.push_back(h);
        run_headers(6, 1'b1);

        directed = '{expected_magic: 32'h5A17_C0DE, expected_major: 16'd3,
                     expected_minor: 16'd1, header_bytes: 16'd64, record_bytes: 16'd32};
        program_registers(directed);
        base = '0;
        base.magic_word     = directed.expected_magic;
        base.major_version  = directed.expected_major;
        base.minor_version  = directed.expected_minor;
        base.table_offset   = 64'd64;
        base.asset_total    = 32'd4;
        base.strings_offset = 64'd192;
        base.strings_size   = 64'd64;
        base.payload_offset = 64'd256;
        base.payload_size   = 64'd1024;
        base.file_bytes     = 63'd1280;
        queued_headers.push_back(base);
        h = base; h.magic_word ^= 32'h8000_0000; queued_headers.push_back(h);
        h = base; h.major_version += 16'd1; queued_headers.push_back(h);
        h = base; h.minor_version ^= 16'h8000; queued_headers.push_back(h);
        h = '0; queued_headers.push_back(h);
        h = '1; queued_headers.push_back(h);
        h = base; h.table_offset = 64'd65; queued_headers.push_back(h);
        h = base; h.strings_offset = 64'd194; queued_headers.push_back(h);
        h = base; h.strings_size = 64'd67; queued_headers.push_back(h);
        h = base; h.payload_offset = 64'd257; queued_headers.push_back(h);
        h = base; h.payload_size = 64'd1026; queued_headers.push_back(h);
        h = base; h.table_offset = 64'hFFFF_FFFF_FFFF_FFC0; queued_headers.push_back(h);
        h = base; h.strings_offset = 64'hFFFF_FFFF_FFFF_FFFC; queued_headers.push_back(h);
        h = base; h.payload_size = 64'hFFFF_FFFF_FFFF_FF00; queued_headers.push_back(h);
        h = base; h.file_bytes = 63'd1279; queued_headers.push_back(h);
        h = base; h.file_bytes = '0; queued_headers.push_back(h);
        h = base; h.strings_offset = 64'd100; h.strings_size = '0; queued_headers.push_back(h);
        h = base; h.strings_offset = 64'd188; queued_headers.push_back(h);
        h = base; h.asset_total = '0; queued_headers.push_back(h);
        h = base; h.asset_total = '1; queued_headers.push_back(h);
        h = base; h.file_bytes = '1; h.payload_offset = 64'h4000_0000_0000_0000;
        h.payload_size = 64'h3FFF_FFFF_FFFF_FFFC; queued_headers.push_back(h);
        h = base; h.payload_offset = '0; h.payload_size = 64'd4; queued_headers.push_back(h);
        h = base; h.strings_offset = 64'hFFFF_FFFF_FFFF_FFFC; h.strings_size = '0;
        queued_headers.push_back(h);
        run_headers(0, 1'b1);

        program_registers('0);
        run_headers(200, 1'b1);
        program_registers('1);
        run_headers(200, 1'b1);
        repeat (3) begin
            c = random_settings($urandom_range(0, 1) == 1);
            program_registers(c);
            run_headers(200, 1'b1);
        end
        c = random_settings(1'b1);
        program_registers(c);
        run_headers(250, 1'b0);

        repeat (PIPE_LATENCY + 8) @(posedge i_clk);
        if (mismatch_count == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end

endmodule

>>> sim.f
rtl/chlc_pkg.sv
rtl/chlc_if.sv
rtl/chlc_cfg_regs.sv
rtl/chlc_mul_stage.sv
rtl/chlc_end_stage.sv
rtl/chlc_judge_stage.sv
rtl/container_header_layout_check_top.sv
tb/container_header_layout_check_top_tb.sv
